[hw/rtl/cpc_pkg.sv]
// cpc_pkg: shared widths, request and result types for the circle pair contact block
// no dependencies; imported by cpc_front, cpc_back and circle_pair_contact
package cpc_pkg;

  // field formats
  localparam int CoordWidth = 24;
  localparam int DirFrac    = 14;
  localparam int RadWidth   = CoordWidth - 1;
  localparam int DirWidth   = DirFrac + 2;

  // internal widths
  localparam int DiffWidth   = CoordWidth + 1;
  localparam int SqWidth     = 2 * CoordWidth;
  localparam int DsqWidth    = 2 * CoordWidth + 1;
  localparam int ProdWidth   = CoordWidth + RadWidth;
  localparam int RemWidth    = 2 * CoordWidth;
  localparam int QuoWidth    = CoordWidth;
  localparam int AccWidth    = DsqWidth + 2 * DirFrac + 7;
  localparam int MagDirWidth = DirFrac + 1;
  localparam int Stages      = (QuoWidth > MagDirWidth) ? QuoWidth : MagDirWidth;

  // queue depth default
  localparam int QueueDepth = 2;

  typedef enum logic [1:0] {
    KindMiss,
    KindSame,
    KindHit
  } kind_e;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic        [RadWidth-1:0]   radius_a;
    logic signed [CoordWidth-1:0] b_x;
    logic signed [CoordWidth-1:0] b_y;
    logic        [RadWidth-1:0]   radius_b;
  } in_t;

  typedef struct packed {
    logic                         collided;
    logic signed [CoordWidth-1:0] contact_x;
    logic signed [CoordWidth-1:0] contact_y;
    logic signed [DirWidth-1:0]   perp_x;
    logic signed [DirWidth-1:0]   perp_y;
  } out_t;

  // classified request handed from front to back
  typedef struct packed {
    kind_e                        kind;
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic                         neg_x;
    logic                         neg_y;
    logic        [ProdWidth-1:0]  prod_x;
    logic        [ProdWidth-1:0]  prod_y;
    logic        [CoordWidth-1:0] sum;
    logic        [DsqWidth-1:0]   dsq;
    logic        [SqWidth-1:0]    sq_x;
    logic        [SqWidth-1:0]    sq_y;
  } mid_t;

endpackage

[hw/rtl/cpc_fifo.sv]
// cpc_fifo: small register queue with full and empty flags
// depends on nothing; used between front and back and at the result side
module cpc_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntWidth = $clog2(Depth + 1);

  logic [Width-1:0]    mem_q [Depth];
  logic [PtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntWidth-1:0] count_q, count_d;
  logic                do_push, do_pop;

  assign full_o  = (count_q == CntWidth'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/cpc_front.sv]
// cpc_front: takes a request, forms differences, squares and products, classifies
// depends on cpc_pkg
module cpc_front
  import cpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output mid_t out_o
);

  logic advance;

  logic                         v1_q, v2_q, v3_q;
  logic signed [DiffWidth-1:0]  dx1_q, dy1_q;
  logic signed [CoordWidth-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic        [RadWidth-1:0]   ra1_q;
  logic        [CoordWidth-1:0] s1_q, s2_q;
  logic        [CoordWidth-1:0] mag_x, mag_y;
  logic                         neg2_x_q, neg2_y_q, same2_q;
  logic        [SqWidth-1:0]    sqx2_q, sqy2_q, ssq2_q;
  logic        [ProdWidth-1:0]  prx2_q, pry2_q;
  logic        [DsqWidth-1:0]   dsq;
  mid_t                         mid_d, mid_q;

  assign advance     = !(v3_q && !out_ready_i);
  assign in_ready_o  = advance;
  assign out_valid_o = v3_q;
  assign out_o       = mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage one: centre differences and radius sum
  always_ff @(posedge clk_i) begin
    if (advance) begin
      dx1_q <= $signed({in_i.b_x[CoordWidth-1], in_i.b_x})
             - $signed({in_i.a_x[CoordWidth-1], in_i.a_x});
      dy1_q <= $signed({in_i.b_y[CoordWidth-1], in_i.b_y})
             - $signed({in_i.a_y[CoordWidth-1], in_i.a_y});
      ax1_q <= in_i.a_x;
      ay1_q <= in_i.a_y;
      ra1_q <= in_i.radius_a;
      s1_q  <= {1'b0, in_i.radius_a} + {1'b0, in_i.radius_b};
    end
  end

  // magnitudes of the differences
  always_comb begin
    mag_x = dx1_q[DiffWidth-1] ? CoordWidth'(-dx1_q) : CoordWidth'(dx1_q);
    mag_y = dy1_q[DiffWidth-1] ? CoordWidth'(-dy1_q) : CoordWidth'(dy1_q);
  end

  // stage two: squares and offset products
  always_ff @(posedge clk_i) begin
    if (advance) begin
      sqx2_q   <= SqWidth'(mag_x) * SqWidth'(mag_x);
      sqy2_q   <= SqWidth'(mag_y) * SqWidth'(mag_y);
      ssq2_q   <= SqWidth'(s1_q) * SqWidth'(s1_q);
      prx2_q   <= ProdWidth'(mag_x) * ProdWidth'(ra1_q);
      pry2_q   <= ProdWidth'(mag_y) * ProdWidth'(ra1_q);
      neg2_x_q <= dx1_q[DiffWidth-1];
      neg2_y_q <= dy1_q[DiffWidth-1];
      same2_q  <= (dx1_q == '0) && (dy1_q == '0);
      ax2_q    <= ax1_q;
      ay2_q    <= ay1_q;
      s2_q     <= s1_q;
    end
  end

  // stage three: squared distance and classification
  always_comb begin
    dsq          = {1'b0, sqx2_q} + {1'b0, sqy2_q};
    mid_d.a_x    = ax2_q;
    mid_d.a_y    = ay2_q;
    mid_d.neg_x  = neg2_x_q;
    mid_d.neg_y  = neg2_y_q;
    mid_d.prod_x = prx2_q;
    mid_d.prod_y = pry2_q;
    mid_d.sum    = s2_q;
    mid_d.dsq    = dsq;
    mid_d.sq_x   = sqx2_q;
    mid_d.sq_y   = sqy2_q;
    if (same2_q) begin
      mid_d.kind = KindSame;
    end else if (dsq <= {1'b0, ssq2_q}) begin
      mid_d.kind = KindHit;
    end else begin
      mid_d.kind = KindMiss;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      mid_q <= mid_d;
    end
  end

endmodule

[hw/rtl/cpc_back.sv]
// cpc_back: pipelined rounded division for the contact point and
// bit-serial normalisation for the direction, then result formatting
// depends on cpc_pkg
module cpc_back
  import cpc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  mid_t in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  typedef struct packed {
    kind_e                        kind;
    logic signed [CoordWidth-1:0] a_x;
    logic signed [CoordWidth-1:0] a_y;
    logic                         neg_x;
    logic                         neg_y;
    logic        [CoordWidth-1:0] sum;
    logic        [DsqWidth-1:0]   dsq;
    logic        [RemWidth-1:0]   rem_x;
    logic        [RemWidth-1:0]   rem_y;
    logic        [QuoWidth-1:0]   quo_x;
    logic        [QuoWidth-1:0]   quo_y;
    logic signed [AccWidth-1:0]   acc_rx;
    logic signed [AccWidth-1:0]   acc_px;
    logic signed [AccWidth-1:0]   acc_ry;
    logic signed [AccWidth-1:0]   acc_py;
    logic        [MagDirWidth-1:0] m_x;
    logic        [MagDirWidth-1:0] m_y;
  } lane_t;

  logic  advance;
  logic  valid_q [Stages+1];
  lane_t lane_q  [Stages+1];
  lane_t lane_in;
  lane_t lane_d  [Stages];

  assign advance     = !(valid_q[Stages] && !out_ready_i);
  assign in_ready_o  = advance;
  assign out_valid_o = valid_q[Stages];

  // initial remainders and accumulators
  always_comb begin
    lane_in.kind   = in_i.kind;
    lane_in.a_x    = in_i.a_x;
    lane_in.a_y    = in_i.a_y;
    lane_in.neg_x  = in_i.neg_x;
    lane_in.neg_y  = in_i.neg_y;
    lane_in.sum    = in_i.sum;
    lane_in.dsq    = in_i.dsq;
    lane_in.rem_x  = {in_i.prod_x, 1'b0};
    lane_in.rem_y  = {in_i.prod_y, 1'b0};
    lane_in.quo_x  = '0;
    lane_in.quo_y  = '0;
    lane_in.acc_rx = (AccWidth'(in_i.sq_y) <<< (2 * DirFrac + 2)) - AccWidth'(in_i.dsq);
    lane_in.acc_ry = (AccWidth'(in_i.sq_x) <<< (2 * DirFrac + 2)) - AccWidth'(in_i.dsq);
    lane_in.acc_px = -$signed(AccWidth'(in_i.dsq));
    lane_in.acc_py = -$signed(AccWidth'(in_i.dsq));
    lane_in.m_x    = '0;
    lane_in.m_y    = '0;
  end

  // one quotient bit in each of the first QuoWidth stages, one direction bit in each of the first DirFrac + 1
  for (genvar j = 0; j < Stages; j++) begin : g_step
    localparam int KDiv    = QuoWidth - 1 - j;
    localparam int KDir    = DirFrac - j;
    localparam int KDirIdx = (KDir >= 0) ? KDir : 0;

    logic        [RemWidth-1:0] div_sh;
    logic signed [AccWidth-1:0] dsq_w, t_x, t_y, r_x, r_y;

    always_comb begin
      lane_d[j] = lane_q[j];
      div_sh    = '0;
      dsq_w     = AccWidth'(lane_q[j].dsq);
      t_x       = '0;
      t_y       = '0;
      r_x       = '0;
      r_y       = '0;
      if (KDiv >= 0) begin
        div_sh = RemWidth'(lane_q[j].sum) << KDiv;
        if (lane_q[j].rem_x >= div_sh) begin
          lane_d[j].rem_x       = lane_q[j].rem_x - div_sh;
          lane_d[j].quo_x[KDiv] = 1'b1;
        end
        if (lane_q[j].rem_y >= div_sh) begin
          lane_d[j].rem_y       = lane_q[j].rem_y - div_sh;
          lane_d[j].quo_y[KDiv] = 1'b1;
        end
      end
      if (KDir >= 0) begin
        t_x = (lane_q[j].acc_px + (dsq_w <<< KDirIdx)) <<< (KDirIdx + 2);
        t_y = (lane_q[j].acc_py + (dsq_w <<< KDirIdx)) <<< (KDirIdx + 2);
        r_x = lane_q[j].acc_rx - t_x;
        r_y = lane_q[j].acc_ry - t_y;
        if (!r_x[AccWidth-1]) begin
          lane_d[j].acc_rx       = r_x;
          lane_d[j].acc_px       = lane_q[j].acc_px + (dsq_w <<< (KDirIdx + 1));
          lane_d[j].m_x[KDirIdx] = 1'b1;
        end
        if (!r_y[AccWidth-1]) begin
          lane_d[j].acc_ry       = r_y;
          lane_d[j].acc_py       = lane_q[j].acc_py + (dsq_w <<< (KDirIdx + 1));
          lane_d[j].m_y[KDirIdx] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        lane_q[j+1] <= lane_d[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lane_q[0] <= lane_in;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= Stages; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (advance) begin
      valid_q[0] <= in_valid_i;
      for (int i = 1; i <= Stages; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  // rounding, offset from centre a, saturation and sign of the direction
  localparam logic signed [CoordWidth+1:0] CoordMax = (CoordWidth+2)'((1 << (CoordWidth - 1)) - 1);
  localparam logic signed [CoordWidth+1:0] CoordMin = -CoordMax - 1;

  logic        [CoordWidth-1:0] q_x, q_y;
  logic signed [CoordWidth+1:0] c_x, c_y;
  logic signed [DirWidth-1:0]   p_x, p_y;
  lane_t                        fin;

  always_comb begin
    fin = lane_q[Stages];
    q_x = CoordWidth'(({1'b0, fin.quo_x} + 1'b1) >> 1);
    q_y = CoordWidth'(({1'b0, fin.quo_y} + 1'b1) >> 1);
    c_x = fin.neg_x ? (CoordWidth+2)'(fin.a_x) - $signed({2'b00, q_x})
                    : (CoordWidth+2)'(fin.a_x) + $signed({2'b00, q_x});
    c_y = fin.neg_y ? (CoordWidth+2)'(fin.a_y) - $signed({2'b00, q_y})
                    : (CoordWidth+2)'(fin.a_y) + $signed({2'b00, q_y});
    if (c_x > CoordMax) c_x = CoordMax;
    else if (c_x < CoordMin) c_x = CoordMin;
    if (c_y > CoordMax) c_y = CoordMax;
    else if (c_y < CoordMin) c_y = CoordMin;
    p_x = fin.neg_y ? -$signed({1'b0, fin.m_x}) : $signed({1'b0, fin.m_x});
    p_y = fin.neg_x ? $signed({1'b0, fin.m_y}) : -$signed({1'b0, fin.m_y});
    out_o = '0;
    unique case (fin.kind)
      KindSame: begin
        out_o.collided  = 1'b1;
        out_o.contact_x = fin.a_x;
        out_o.contact_y = fin.a_y;
      end
      KindHit: begin
        out_o.collided  = 1'b1;
        out_o.contact_x = CoordWidth'(c_x);
        out_o.contact_y = CoordWidth'(c_y);
        out_o.perp_x    = p_x;
        out_o.perp_y    = p_y;
      end
      default: begin
        out_o = '0;
      end
    endcase
  end

endmodule

[hw/rtl/circle_pair_contact.sv]
// circle_pair_contact: contact test for two circles, top level
// depends on cpc_pkg, cpc_front, cpc_back and cpc_fifo
//
//   channel   direction  handshake             payload
//   request   in         push / full           in_req_i  (cpc_pkg::in_t)
//   result    out        pop / empty           res_o     (cpc_pkg::out_t)
//
// one request per cycle sustained while results are popped; a request passes
// 3 front stages, the queue hop, 1 + Stages back stages (of those after the first,
// the first QuoWidth form quotient bits and the first DirFrac + 1 direction bits)
// and the result queue hop; the first of these loads at the accepting edge
// reset clears every valid bit and both queues; payload registers are not reset
// a stalled result stops the back pipeline, then the middle queue, then the front
module circle_pair_contact
  import cpc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_t  in_req_i,
  input  logic pop,
  output logic empty,
  output out_t res_o
);

  logic front_ready, front_valid;
  mid_t front_out, mid_head;
  logic mid_full, mid_empty;
  logic back_ready, back_valid;
  out_t back_out;
  logic res_full;

  assign full = !front_ready;

  // front: differences, squares, classification
  cpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_ready_o  (front_ready),
    .in_i        (in_req_i),
    .out_valid_o (front_valid),
    .out_ready_i (!mid_full),
    .out_o       (front_out)
  );

  // decoupling queue between front and back
  cpc_fifo #(
    .Width ($bits(mid_t)),
    .Depth (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_out),
    .full_o  (mid_full),
    .pop_i   (back_ready),
    .data_o  (mid_head),
    .empty_o (mid_empty)
  );

  // back: division and direction normalisation
  cpc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (!mid_empty),
    .in_ready_o  (back_ready),
    .in_i        (mid_head),
    .out_valid_o (back_valid),
    .out_ready_i (!res_full),
    .out_o       (back_out)
  );

  // result queue
  cpc_fifo #(
    .Width ($bits(out_t)),
    .Depth (QUEUE_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (back_valid),
    .data_i  (back_out),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_o),
    .empty_o (empty)
  );

endmodule
